>>> sv/mptd_pkg.sv
package mptd_pkg;

   // token kinds
   localparam logic [2:0] KIND_MAP    = 3'd0;
   localparam logic [2:0] KIND_ARRAY  = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_BIN    = 3'd3;
   localparam logic [2:0] KIND_UINT   = 3'd4;
   localparam logic [2:0] KIND_BOOL   = 3'd5;
   localparam logic [2:0] KIND_DATA   = 3'd6;
   localparam logic [2:0] KIND_ERROR  = 3'd7;

   // error codes
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_HEADER = 3'd1;
   localparam logic [2:0] ERR_ENDS   = 3'd2;
   localparam logic [2:0] ERR_STRLEN = 3'd3;
   localparam logic [2:0] ERR_BINLEN = 3'd4;

   // header bytes outside the fix* ranges
   localparam logic [7:0] HDR_FALSE  = 8'hC2;
   localparam logic [7:0] HDR_TRUE   = 8'hC3;
   localparam logic [7:0] HDR_BIN8   = 8'hC4;
   localparam logic [7:0] HDR_BIN16  = 8'hC5;
   localparam logic [7:0] HDR_UINT8  = 8'hCC;
   localparam logic [7:0] HDR_UINT16 = 8'hCD;
   localparam logic [7:0] HDR_UINT32 = 8'hCE;
   localparam logic [7:0] HDR_UINT64 = 8'hCF;
   localparam logic [7:0] HDR_STR8   = 8'hD9;
   localparam logic [7:0] HDR_MAP16  = 8'hDE;

   // csr register indexes
   localparam logic CSR_MAX_STRING_LEN = 1'b0;
   localparam logic CSR_MAX_BIN_LEN    = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  max_string_len;
      logic [15:0] max_bin_len;
   } limits_type;

   // one decoded byte: an optional main result and an optional
   // "ends inside token" error behind it
   typedef struct packed {
      logic        has_main;
      logic [2:0]  kind;
      logic [63:0] value;
      logic [7:0]  data;
      logic [2:0]  err;
      logic        tail_err;
   } entry_type;

endpackage

>>> sv/mptd_if.sv
interface mptd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface mptd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [63:0] token_value;
   logic [7:0]  data_byte;
   logic [2:0]  error_code;
   logic        end_of_run;

   modport source (output valid, output token_kind, output token_value,
                   output data_byte, output error_code, output end_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_value,
                   input data_byte, input error_code, input end_of_run,
                   output ready);
endinterface

interface mptd_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mptd_front.sv
module mptd_front (
   input  logic                 clock,
   input  logic                 reset,
   mptd_req_if.sink             req,
   input  mptd_pkg::limits_type limits,
   input  logic                 push_ready,
   output logic                 push_valid,
   output mptd_pkg::entry_type  push_entry
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_EXTRA,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pkind_ff, pkind_in;
   logic [3:0]  left_ff, left_in;
   logic [63:0] accum_ff, accum_in;
   logic [15:0] pay_ff, pay_in;

   logic        accept;
   logic [7:0]  b;
   logic [63:0] accum_shift;
   logic [3:0]  left_dec;
   logic [15:0] pay_dec;
   logic        main_v;
   logic [2:0]  m_kind;
   logic [63:0] m_value;
   logic [7:0]  m_data;
   logic [2:0]  m_err;
   logic        blob_go;
   logic [2:0]  blob_kind;
   logic [15:0] blob_len;
   logic [15:0] blob_limit;
   logic        tail;

   assign accept      = req.valid && push_ready;
   assign req.ready   = push_ready;
   assign b           = req.byte_in;
   assign accum_shift = {accum_ff[55:0], b};
   assign left_dec    = left_ff - {3'b000, left_ff != 4'd0};
   assign pay_dec     = pay_ff - {15'd0, pay_ff != 16'd0};

   always_comb begin
      phase_in   = phase_ff;
      pkind_in   = pkind_ff;
      left_in    = left_ff;
      accum_in   = accum_ff;
      pay_in     = pay_ff;
      main_v     = 1'b0;
      m_kind     = mptd_pkg::KIND_ERROR;
      m_value    = 64'd0;
      m_data     = 8'd0;
      m_err      = mptd_pkg::ERR_NONE;
      blob_go    = 1'b0;
      blob_kind  = mptd_pkg::KIND_STRING;
      blob_len   = 16'd0;
      blob_limit = 16'd0;
      tail       = 1'b0;

      unique case (phase_ff)
         PH_EXTRA: begin
            accum_in = accum_shift;
            left_in  = left_dec;
            if (left_dec == 4'd0) begin
               if (pkind_ff == mptd_pkg::KIND_STRING || pkind_ff == mptd_pkg::KIND_BIN) begin
                  blob_go   = 1'b1;
                  blob_kind = pkind_ff;
                  blob_len  = accum_shift[15:0];
               end else begin
                  main_v  = 1'b1;
                  m_kind  = pkind_ff;
                  m_value = accum_shift;
               end
               phase_in = PH_HEADER;
               pkind_in = 3'd0;
               accum_in = 64'd0;
               pay_in   = 16'd0;
            end
         end
         PH_PAYLOAD: begin
            main_v = 1'b1;
            m_kind = mptd_pkg::KIND_DATA;
            m_data = b;
            pay_in = pay_dec;
            if (pay_dec == 16'd0) begin
               phase_in = PH_HEADER;
               pkind_in = 3'd0;
               left_in  = 4'd0;
               accum_in = 64'd0;
            end
         end
         default: begin
            if (!b[7]) begin
               main_v  = 1'b1;
               m_kind  = mptd_pkg::KIND_UINT;
               m_value = {57'd0, b[6:0]};
            end else if (b[7:4] == 4'h8) begin
               main_v  = 1'b1;
               m_kind  = mptd_pkg::KIND_MAP;
               m_value = {60'd0, b[3:0]};
            end else if (b[7:4] == 4'h9) begin
               main_v  = 1'b1;
               m_kind  = mptd_pkg::KIND_ARRAY;
               m_value = {60'd0, b[3:0]};
            end else if (b[7:5] == 3'b101) begin
               blob_go   = 1'b1;
               blob_kind = mptd_pkg::KIND_STRING;
               blob_len  = {11'd0, b[4:0]};
            end else begin
               case (b)
                  mptd_pkg::HDR_FALSE: begin
                     main_v = 1'b1;
                     m_kind = mptd_pkg::KIND_BOOL;
                  end
                  mptd_pkg::HDR_TRUE: begin
                     main_v  = 1'b1;
                     m_kind  = mptd_pkg::KIND_BOOL;
                     m_value = 64'd1;
                  end
                  mptd_pkg::HDR_BIN8: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_BIN; left_in = 4'd1;
                  end
                  mptd_pkg::HDR_BIN16: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_BIN; left_in = 4'd2;
                  end
                  mptd_pkg::HDR_UINT8: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_UINT; left_in = 4'd1;
                  end
                  mptd_pkg::HDR_UINT16: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_UINT; left_in = 4'd2;
                  end
                  mptd_pkg::HDR_UINT32: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_UINT; left_in = 4'd4;
                  end
                  mptd_pkg::HDR_UINT64: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_UINT; left_in = 4'd8;
                  end
                  mptd_pkg::HDR_STR8: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_STRING; left_in = 4'd1;
                  end
                  mptd_pkg::HDR_MAP16: begin
                     phase_in = PH_EXTRA; pkind_in = mptd_pkg::KIND_MAP; left_in = 4'd2;
                  end
                  default: begin
                     main_v = 1'b1;
                     m_kind = mptd_pkg::KIND_ERROR;
                     m_err  = mptd_pkg::ERR_HEADER;
                     m_data = b;
                  end
               endcase
               accum_in = 64'd0;
            end
         end
      endcase

      // string/bin header: length check, then payload phase if it passes and is non-empty
      if (blob_go) begin
         blob_limit = (blob_kind == mptd_pkg::KIND_STRING) ?
                      {8'd0, limits.max_string_len} : limits.max_bin_len;
         main_v   = 1'b1;
         phase_in = PH_HEADER;
         pkind_in = 3'd0;
         left_in  = 4'd0;
         accum_in = 64'd0;
         pay_in   = 16'd0;
         if (blob_len > blob_limit) begin
            m_kind = mptd_pkg::KIND_ERROR;
            m_err  = (blob_kind == mptd_pkg::KIND_STRING) ?
                     mptd_pkg::ERR_STRLEN : mptd_pkg::ERR_BINLEN;
         end else begin
            m_kind  = blob_kind;
            m_value = {48'd0, blob_len};
            if (blob_len != 16'd0) begin
               phase_in = PH_PAYLOAD;
               pay_in   = blob_len;
            end
         end
      end

      // bad header drops back to a clean header phase
      if (main_v && m_kind == mptd_pkg::KIND_ERROR) begin
         phase_in = PH_HEADER;
         pkind_in = 3'd0;
         left_in  = 4'd0;
         accum_in = 64'd0;
         pay_in   = 16'd0;
      end

      // buffer ended mid-token
      if (req.last_byte && phase_in != PH_HEADER) begin
         tail     = 1'b1;
         phase_in = PH_HEADER;
         pkind_in = 3'd0;
         left_in  = 4'd0;
         accum_in = 64'd0;
         pay_in   = 16'd0;
      end
   end

   assign push_valid          = accept && (main_v || tail);
   assign push_entry.has_main = main_v;
   assign push_entry.kind     = m_kind;
   assign push_entry.value    = m_value;
   assign push_entry.data     = m_data;
   assign push_entry.err      = m_err;
   assign push_entry.tail_err = tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pkind_ff <= 3'd0;
         left_ff  <= 4'd0;
         accum_ff <= 64'd0;
         pay_ff   <= 16'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pkind_ff <= pkind_in;
         left_ff  <= left_in;
         accum_ff <= accum_in;
         pay_ff   <= pay_in;
      end
   end

endmodule

>>> sv/mptd_queue.sv
module mptd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  mptd_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                head_valid,
   output mptd_pkg::entry_type head
);

   mptd_pkg::entry_type                 store_ff [mptd_pkg::QUEUE_DEPTH];
   logic [mptd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mptd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mptd_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign push_ready = count_ff != mptd_pkg::QUEUE_CNT_W'(mptd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/mptd_back.sv
module mptd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  mptd_pkg::entry_type head,
   output logic                pop,
   mptd_rsp_if.source          rsp
);

   logic        valid_ff, valid_in;
   logic        sub_ff, sub_in;   // main result of head already sent
   logic [2:0]  kind_ff, kind_in;
   logic [63:0] value_ff, value_in;
   logic [7:0]  data_ff, data_in;
   logic [2:0]  err_ff, err_in;
   logic        eor_ff, eor_in;
   logic        load;

   assign load = !valid_ff || rsp.ready;

   always_comb begin
      pop      = 1'b0;
      sub_in   = sub_ff;
      valid_in = valid_ff && !rsp.ready;
      kind_in  = kind_ff;
      value_in = value_ff;
      data_in  = data_ff;
      err_in   = err_ff;
      eor_in   = eor_ff;
      if (load && head_valid) begin
         valid_in = 1'b1;
         if (head.has_main && !sub_ff) begin
            kind_in  = head.kind;
            value_in = head.value;
            data_in  = head.data;
            err_in   = head.err;
            eor_in   = !head.tail_err;
            if (head.tail_err) begin
               sub_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            kind_in  = mptd_pkg::KIND_ERROR;
            value_in = 64'd0;
            data_in  = 8'd0;
            err_in   = mptd_pkg::ERR_ENDS;
            eor_in   = 1'b1;
            pop      = 1'b1;
            sub_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      data_ff  <= data_in;
      err_ff   <= err_in;
      eor_ff   <= eor_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.token_kind  = kind_ff;
   assign rsp.token_value = value_ff;
   assign rsp.data_byte   = data_ff;
   assign rsp.error_code  = err_ff;
   assign rsp.end_of_run  = eor_ff;

endmodule

>>> sv/msgpack_token_decoder_core.sv
// Streaming MessagePack token decoder.
// req_chan: one stream byte per item plus a last_byte flag on the buffer's
//   final byte. rsp_chan: one token per item (header tokens, payload bytes,
//   error tokens); end_of_run marks the last token a given byte caused.
// csr_chan: index 0 writes max_string_len (data[7:0]), index 1 writes
//   max_bin_len (data[15:0]); csr_ready is always high. Write only while idle.
// A byte's first token is written into the queue by the front decode, then
//   loaded into the output register, which drives rsp_chan.
// Throughput: one byte per cycle while the queue has room. Each byte makes
//   at most two tokens; the second (stream ends inside a token) needs an
//   extra output slot, absorbed by the 4-entry queue between front and back.
// Reset: parser returns to waiting for a header byte, queue and output
//   register empty, limits back to 255 and 65535. No clearing pass.
// Back-pressure: when rsp_ready is low the output register holds its token;
//   the queue fills and req_ready drops only once all four entries are taken.
module msgpack_token_decoder_core (
   input  logic       clock,
   input  logic       reset,
   mptd_req_if.sink   req_chan,
   mptd_rsp_if.source rsp_chan,
   mptd_csr_if.sink   csr_chan
);

   mptd_pkg::limits_type limits_ff, limits_in;
   mptd_pkg::entry_type  push_entry;
   mptd_pkg::entry_type  head;
   logic                 push_valid;
   logic                 push_ready;
   logic                 head_valid;
   logic                 pop;

   // config registers; writes always accepted
   assign csr_chan.ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            mptd_pkg::CSR_MAX_STRING_LEN: limits_in.max_string_len = csr_chan.data[7:0];
            mptd_pkg::CSR_MAX_BIN_LEN:    limits_in.max_bin_len    = csr_chan.data;
            default:                      limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_string_len <= 8'hFF;
         limits_ff.max_bin_len    <= 16'hFFFF;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // front: byte-at-a-time parser
   mptd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .limits     (limits_ff),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decoupling queue
   mptd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: splits entries into tokens, drives the output register
   mptd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

>>> sim/msgpack_token_decoder_core_tb.sv
module msgpack_token_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one token as it leaves the decoder
   typedef struct {
      logic [2:0]  kind;
      logic [63:0] value;
      logic [7:0]  data;
      logic [2:0]  err;
      logic        eor;
   } mp_token_type;

   // one stream byte; table rows may carry a hand-written token to check against
   typedef struct {
      logic [7:0]   b;
      logic         last;
      bit           typed;
      mp_token_type want;
   } stream_byte_type;

   typedef enum logic [1:0] {PARSE_HEADER, PARSE_EXT, PARSE_PAYLOAD} parse_phase_type;

   logic clock = 1'b0;
   logic reset;

   mptd_req_if req_chan ();
   mptd_rsp_if rsp_chan ();
   mptd_csr_if csr_chan ();

   msgpack_token_decoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Parser mirror: tracks the decoder's state and limits, one byte at a time
   // ---------------------------------------------------------------------------
   parse_phase_type m_phase;
   logic [2:0]      m_kind;          // kind waiting on its extension bytes
   logic [3:0]      m_ext_left;
   logic [63:0]     m_accum;         // big-endian collector for extension bytes
   logic [15:0]     m_payload_left;
   logic [7:0]      m_max_str;
   logic [15:0]     m_max_bin;

   mp_token_type    step_out [2];    // tokens caused by the latest byte
   mp_token_type    due_tokens [$];  // tokens the decoder still owes, oldest first
   stream_byte_type stream_q [$];    // bytes queued for the input side

   int mismatch_count = 0;
   int items_sent;
   int hold_off_at;               // item count at which the long rsp stall starts
   bit send_idle_en;
   bit rsp_idle_en;
   bit hold_off_req;

   function automatic mp_token_type make_token(logic [2:0] kind, logic [63:0] value,
                                               logic [7:0] data, logic [2:0] err);
      mp_token_type t;
      t.kind  = kind;
      t.value = value;
      t.data  = data;
      t.err   = err;
      t.eor   = 1'b0;
      return t;
   endfunction

   function automatic void clear_parser();
      m_phase        = PARSE_HEADER;
      m_kind         = '0;
      m_ext_left     = '0;
      m_accum        = '0;
      m_payload_left = '0;
   endfunction

   // string/bin header: either the header token or a length error, never both
   function automatic mp_token_type open_blob(logic [2:0] kind, logic [15:0] len);
      logic [15:0] limit;
      limit = (kind == mptd_pkg::KIND_STRING) ? {8'd0, m_max_str} : m_max_bin;
      clear_parser();
      if (len > limit)
         return make_token(mptd_pkg::KIND_ERROR, 64'd0, 8'd0,
                           (kind == mptd_pkg::KIND_STRING) ?
                           mptd_pkg::ERR_STRLEN : mptd_pkg::ERR_BINLEN);
      if (len != 0) begin
         m_phase        = PARSE_PAYLOAD;
         m_payload_left = len;
      end
      return make_token(kind, {48'd0, len}, 8'd0, mptd_pkg::ERR_NONE);
   endfunction

   function automatic void open_ext(logic [2:0] kind, logic [3:0] count);
      m_phase    = PARSE_EXT;
      m_kind     = kind;
      m_ext_left = count;
      m_accum    = '0;
   endfunction

   // advances the mirror by one byte; returns how many tokens it caused
   function automatic int decode_byte(logic [7:0] b, logic last);
      int n;
      n = 0;
      case (m_phase)
         PARSE_EXT: begin
            m_accum = {m_accum[55:0], b};
            if (m_ext_left != 0)
               m_ext_left--;
            if (m_ext_left == 0) begin
               if (m_kind == mptd_pkg::KIND_STRING || m_kind == mptd_pkg::KIND_BIN) begin
                  step_out[0] = open_blob(m_kind, m_accum[15:0]);
               end else begin
                  step_out[0] = make_token(m_kind, m_accum, 8'd0, mptd_pkg::ERR_NONE);
                  clear_parser();
               end
               n = 1;
            end
         end
         PARSE_PAYLOAD: begin
            step_out[0] = make_token(mptd_pkg::KIND_DATA, 64'd0, b, mptd_pkg::ERR_NONE);
            n = 1;
            if (m_payload_left != 0)
               m_payload_left--;
            if (m_payload_left == 0)
               clear_parser();
         end
         default: begin
            n = 1;
            if (b <= 8'h7F) begin
               step_out[0] = make_token(mptd_pkg::KIND_UINT, {56'd0, b}, 8'd0,
                                        mptd_pkg::ERR_NONE);
            end else if (b <= 8'h8F) begin
               step_out[0] = make_token(mptd_pkg::KIND_MAP, {60'd0, b[3:0]}, 8'd0,
                                        mptd_pkg::ERR_NONE);
            end else if (b <= 8'h9F) begin
               step_out[0] = make_token(mptd_pkg::KIND_ARRAY, {60'd0, b[3:0]}, 8'd0,
                                        mptd_pkg::ERR_NONE);
            end else if (b <= 8'hBF) begin
               step_out[0] = open_blob(mptd_pkg::KIND_STRING, {11'd0, b[4:0]});
            end else begin
               n = 0;
               case (b)
                  mptd_pkg::HDR_FALSE: begin
                     step_out[0] = make_token(mptd_pkg::KIND_BOOL, 64'd0, 8'd0,
                                              mptd_pkg::ERR_NONE);
                     n = 1;
                  end
                  mptd_pkg::HDR_TRUE: begin
                     step_out[0] = make_token(mptd_pkg::KIND_BOOL, 64'd1, 8'd0,
                                              mptd_pkg::ERR_NONE);
                     n = 1;
                  end
                  mptd_pkg::HDR_BIN8:   open_ext(mptd_pkg::KIND_BIN, 4'd1);
                  mptd_pkg::HDR_BIN16:  open_ext(mptd_pkg::KIND_BIN, 4'd2);
                  mptd_pkg::HDR_UINT8:  open_ext(mptd_pkg::KIND_UINT, 4'd1);
                  mptd_pkg::HDR_UINT16: open_ext(mptd_pkg::KIND_UINT, 4'd2);
                  mptd_pkg::HDR_UINT32: open_ext(mptd_pkg::KIND_UINT, 4'd4);
                  mptd_pkg::HDR_UINT64: open_ext(mptd_pkg::KIND_UINT, 4'd8);
                  mptd_pkg::HDR_STR8:   open_ext(mptd_pkg::KIND_STRING, 4'd1);
                  mptd_pkg::HDR_MAP16:  open_ext(mptd_pkg::KIND_MAP, 4'd2);
                  default: begin
                     clear_parser();
                     step_out[0] = make_token(mptd_pkg::KIND_ERROR, 64'd0, b,
                                              mptd_pkg::ERR_HEADER);
                     n = 1;
                  end
               endcase
            end
         end
      endcase
      // buffer ran out mid-token: truncation error goes behind anything above
      if (last && m_phase != PARSE_HEADER) begin
         clear_parser();
         step_out[n] = make_token(mptd_pkg::KIND_ERROR, 64'd0, 8'd0, mptd_pkg::ERR_ENDS);
         n++;
      end
      if (n > 0)
         step_out[n-1].eor = 1'b1;
      return n;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic stream_byte_type raw_byte(logic [7:0] b, logic last);
      stream_byte_type r;
      r.b     = b;
      r.last  = last;
      r.typed = 1'b0;
      r.want  = make_token(mptd_pkg::KIND_DATA, 64'd0, 8'd0, mptd_pkg::ERR_NONE);
      return r;
   endfunction

   // table row whose single token is written out by hand
   function automatic stream_byte_type typed_row(logic [7:0] b, logic last,
                                                 logic [2:0] kind, logic [63:0] value,
                                                 logic [7:0] data, logic [2:0] err);
      stream_byte_type r;
      r          = raw_byte(b, last);
      r.typed    = 1'b1;
      r.want     = make_token(kind, value, data, err);
      r.want.eor = 1'b1;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // length pick: mostly small, sometimes anywhere, sometimes the maximum
   function automatic int wide_len(int top);
      int r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return top;
      if (r < 3)
         return $urandom_range(0, top);
      return $urandom_range(0, 40);
   endfunction

   function automatic logic [7:0] bad_header();
      logic [7:0] b;
      do
         b = 8'($urandom_range(8'hC0, 8'hFF));
      while (b inside {mptd_pkg::HDR_FALSE, mptd_pkg::HDR_TRUE, mptd_pkg::HDR_BIN8,
                       mptd_pkg::HDR_BIN16, mptd_pkg::HDR_UINT8, mptd_pkg::HDR_UINT16,
                       mptd_pkg::HDR_UINT32, mptd_pkg::HDR_UINT64, mptd_pkg::HDR_STR8,
                       mptd_pkg::HDR_MAP16});
      return b;
   endfunction

   // Builds one token's bytes into stream_q. Mostly well-formed tokens; some are
   // cut short with last_byte on the cut, some are bad headers or single noise
   // bytes. Cut tokens and noise always carry last_byte, which puts the decoder
   // back to the header state, so the next token starts on a boundary.
   task automatic queue_token();
      logic [7:0]  bytes [$];
      logic [15:0] limit;
      int          pick, len, keep, k, fill;
      bit          is_blob, is_str, cut, last_flag;
      is_blob = 1'b0;
      is_str  = 1'b0;
      cut     = 1'b0;
      len     = 0;
      pick    = $urandom_range(0, 99);
      if (pick < 8) begin
         bytes.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 14) begin
         bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));   // fixmap / fixarray
      end else if (pick < 18) begin
         bytes.push_back($urandom_range(0, 1) ? mptd_pkg::HDR_TRUE : mptd_pkg::HDR_FALSE);
      end else if (pick < 30) begin
         len = $urandom_range(0, 31);
         bytes.push_back(8'(8'hA0 + len));
         is_blob = 1'b1;
         is_str  = 1'b1;
      end else if (pick < 40) begin
         len = wide_len(255);
         bytes.push_back(mptd_pkg::HDR_STR8);
         bytes.push_back(8'(len));
         is_blob = 1'b1;
         is_str  = 1'b1;
      end else if (pick < 48) begin
         len = wide_len(255);
         bytes.push_back(mptd_pkg::HDR_BIN8);
         bytes.push_back(8'(len));
         is_blob = 1'b1;
      end else if (pick < 56) begin
         len = wide_len(65535);
         bytes.push_back(mptd_pkg::HDR_BIN16);
         bytes.push_back(8'(len >> 8));
         bytes.push_back(8'(len));
         is_blob = 1'b1;
      end else if (pick < 76) begin
         k = $urandom_range(0, 3);
         case (k)
            0:       bytes.push_back(mptd_pkg::HDR_UINT8);
            1:       bytes.push_back(mptd_pkg::HDR_UINT16);
            2:       bytes.push_back(mptd_pkg::HDR_UINT32);
            default: bytes.push_back(mptd_pkg::HDR_UINT64);
         endcase
         fill = $urandom_range(0, 5);   // all-zero and all-ones values now and then
         for (int i = 0; i < (1 << k); i++)
            bytes.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      end else if (pick < 84) begin
         bytes.push_back(mptd_pkg::HDR_MAP16);
         bytes.push_back(8'($urandom_range(0, 255)));
         bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
         bytes.push_back(bad_header());
      end else begin
         bytes.push_back(8'($urandom_range(0, 255)));
         cut = 1'b1;
      end

      // payload only when the length passes the limit now in force
      if (is_blob) begin
         limit = is_str ? {8'd0, m_max_str} : m_max_bin;
         if (len <= limit) begin
            keep = len;
            // long blobs are mostly cut after a few bytes to keep the run short;
            // anything over 300 bytes is always cut
            if (len > 40 && ($urandom_range(0, 3) != 0 || len > 300)) begin
               keep = $urandom_range(1, 6);
               cut  = 1'b1;
            end
            repeat (keep) bytes.push_back(8'($urandom_range(0, 255)));
         end
      end

      if (!cut && bytes.size() > 1 && $urandom_range(0, 99) < 6) begin
         k = $urandom_range(1, bytes.size() - 1);
         while (bytes.size() > k)
            void'(bytes.pop_back());
         cut = 1'b1;
      end

      // last_byte also lands on clean token boundaries from time to time
      last_flag = cut || ($urandom_range(0, 9) == 0);
      foreach (bytes[i])
         stream_q.push_back(raw_byte(bytes[i], (i == bytes.size() - 1) && last_flag));
   endtask

   // Offers one byte from the current falling edge until accepted, updates the
   // mirror, then maybe idles. valid stays high into the next call when no gap.
   task automatic send_byte(input stream_byte_type it);
      int n, gap;
      req_chan.valid     <= 1'b1;
      req_chan.byte_in   <= it.b;
      req_chan.last_byte <= it.last;
      do
         @(posedge clock);
      while (!req_chan.ready);
      n = decode_byte(it.b, it.last);
      if (it.typed)
         due_tokens.push_back(it.want);
      else
         for (int i = 0; i < n; i++)
            due_tokens.push_back(step_out[i]);
      items_sent++;
      if (items_sent == hold_off_at)
         hold_off_req = 1'b1;
      gap = (send_idle_en && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_stream();
      while (stream_q.size() != 0)
         send_byte(stream_q.pop_front());
   endtask

   // Waits for every owed token, then lets the pipeline settle.
   // Ends on a falling edge with the input side quiet.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (due_tokens.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // both limits, back to back; upper bits of the string write are don't-care
   task automatic write_limits(input logic [7:0] str_lim, input logic [15:0] bin_lim);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= mptd_pkg::CSR_MAX_STRING_LEN;
      csr_chan.data  <= {8'($urandom_range(0, 255)), str_lim};
      do
         @(posedge clock);
      while (!csr_chan.ready);
      m_max_str = str_lim;
      @(negedge clock);
      csr_chan.index <= mptd_pkg::CSR_MAX_BIN_LEN;
      csr_chan.data  <= bin_lim;
      do
         @(posedge clock);
      while (!csr_chan.ready);
      m_max_bin = bin_lim;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // one setting of the limits, then random tokens until n_items bytes went in
   task automatic run_phase(input logic [7:0] str_lim, input logic [15:0] bin_lim,
                            input int n_items, input bit idle, input int hold_at);
      int first;
      write_limits(str_lim, bin_lim);
      send_idle_en = idle;
      hold_off_at  = (hold_at > 0) ? items_sent + hold_at : -1;
      @(posedge clock);
      rsp_idle_en = idle;
      @(negedge clock);
      first = items_sent;
      while (items_sent - first < n_items) begin
         queue_token();
         drain_stream();
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_flow
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.byte_in   = 8'd0;
      req_chan.last_byte = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = mptd_pkg::CSR_MAX_STRING_LEN;
      csr_chan.data      = 16'd0;
      send_idle_en       = 1'b1;
      rsp_idle_en        = 1'b1;
      hold_off_req       = 1'b0;
      hold_off_at        = -1;
      items_sent         = 0;
      m_max_str          = 8'd255;
      m_max_bin          = 16'hFFFF;
      clear_parser();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, limits at their reset values. Rows with a token spelled
      // out must give exactly that one token; the rest go through the mirror.
      stream_q.push_back(typed_row(8'h00, 1'b0, mptd_pkg::KIND_UINT, 64'd0, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(typed_row(8'h7F, 1'b0, mptd_pkg::KIND_UINT, 64'd127, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(typed_row(8'h80, 1'b0, mptd_pkg::KIND_MAP, 64'd0, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(typed_row(8'h8F, 1'b0, mptd_pkg::KIND_MAP, 64'd15, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(typed_row(8'h9F, 1'b0, mptd_pkg::KIND_ARRAY, 64'd15, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(typed_row(mptd_pkg::HDR_FALSE, 1'b0, mptd_pkg::KIND_BOOL, 64'd0,
                                   8'd0, mptd_pkg::ERR_NONE));
      // last_byte on a complete token: nothing extra
      stream_q.push_back(typed_row(mptd_pkg::HDR_TRUE, 1'b1, mptd_pkg::KIND_BOOL, 64'd1,
                                   8'd0, mptd_pkg::ERR_NONE));
      // nil and negative fixint are not supported
      stream_q.push_back(typed_row(8'hC0, 1'b0, mptd_pkg::KIND_ERROR, 64'd0, 8'hC0,
                                   mptd_pkg::ERR_HEADER));
      stream_q.push_back(typed_row(8'hFF, 1'b0, mptd_pkg::KIND_ERROR, 64'd0, 8'hFF,
                                   mptd_pkg::ERR_HEADER));
      // empty string: header only
      stream_q.push_back(typed_row(8'hA0, 1'b0, mptd_pkg::KIND_STRING, 64'd0, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(typed_row(8'hA2, 1'b0, mptd_pkg::KIND_STRING, 64'd2, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(raw_byte(8'h41, 1'b0));
      stream_q.push_back(raw_byte(8'h42, 1'b0));
      stream_q.push_back(raw_byte(mptd_pkg::HDR_UINT8, 1'b0));
      stream_q.push_back(typed_row(8'hFF, 1'b0, mptd_pkg::KIND_UINT, 64'd255, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(raw_byte(mptd_pkg::HDR_UINT16, 1'b0));
      stream_q.push_back(raw_byte(8'hFF, 1'b0));
      stream_q.push_back(typed_row(8'hFF, 1'b0, mptd_pkg::KIND_UINT, 64'd65535, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(raw_byte(mptd_pkg::HDR_BIN8, 1'b0));
      stream_q.push_back(typed_row(8'h00, 1'b0, mptd_pkg::KIND_BIN, 64'd0, 8'd0,
                                   mptd_pkg::ERR_NONE));
      stream_q.push_back(raw_byte(mptd_pkg::HDR_BIN16, 1'b0));
      stream_q.push_back(raw_byte(8'hFF, 1'b0));
      stream_q.push_back(typed_row(8'hFF, 1'b0, mptd_pkg::KIND_BIN, 64'd65535, 8'd0,
                                   mptd_pkg::ERR_NONE));
      // buffer ends inside the payload: data byte, then the truncation error
      stream_q.push_back(raw_byte(8'h00, 1'b1));
      stream_q.push_back(raw_byte(mptd_pkg::HDR_MAP16, 1'b0));
      stream_q.push_back(raw_byte(8'hFF, 1'b0));
      stream_q.push_back(typed_row(8'hFF, 1'b0, mptd_pkg::KIND_MAP, 64'd65535, 8'd0,
                                   mptd_pkg::ERR_NONE));
      // buffer ends inside the extension bytes
      stream_q.push_back(typed_row(mptd_pkg::HDR_UINT64, 1'b1, mptd_pkg::KIND_ERROR, 64'd0,
                                   8'd0, mptd_pkg::ERR_ENDS));
      drain_stream();
      wait_idle();

      // Random phases over several limit settings, extremes included. The second
      // runs without gaps and with one long rsp stall so the queue backs up.
      run_phase(8'd0,   16'd0,   100, 1'b1, 0);
      run_phase(8'd16,  16'd300, 150, 1'b0, 40);
      run_phase(8'($urandom_range(1, 254)), 16'($urandom_range(1, 65534)), 150, 1'b1, 0);
      run_phase(8'd255, 16'hFFFF, 150, 1'b1, 0);
      run_phase(8'd1,   16'd1,   100, 1'b1, 0);

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // rsp side: random stalls, plus one long hold-off when asked for
   initial begin : rsp_ready_drive
      int stall;
      stall          = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall == 0 && hold_off_req) begin
            hold_off_req = 1'b0;
            stall        = 100;
         end else if (stall == 0 && rsp_idle_en && $urandom_range(0, 99) < 20) begin
            stall = idle_len();
         end
         if (stall != 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // every accepted token against the oldest one owed
   always @(posedge clock) begin : rsp_check
      mp_token_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_tokens.size() == 0) begin
            $error("unexpected token: kind %0d value %0h data %0h err %0d",
                   rsp_chan.token_kind, rsp_chan.token_value, rsp_chan.data_byte,
                   rsp_chan.error_code);
            mismatch_count++;
         end else begin
            want = due_tokens.pop_front();
            if (rsp_chan.token_kind !== want.kind) begin
               $error("token_kind: expected %0d, got %0d", want.kind, rsp_chan.token_kind);
               mismatch_count++;
            end
            if (rsp_chan.token_value !== want.value) begin
               $error("token_value: expected %0h, got %0h", want.value, rsp_chan.token_value);
               mismatch_count++;
            end
            if (rsp_chan.data_byte !== want.data) begin
               $error("data_byte: expected %0h, got %0h", want.data, rsp_chan.data_byte);
               mismatch_count++;
            end
            if (rsp_chan.error_code !== want.err) begin
               $error("error_code: expected %0d, got %0d", want.err, rsp_chan.error_code);
               mismatch_count++;
            end
            if (rsp_chan.end_of_run !== want.eor) begin
               $error("end_of_run: expected %0d, got %0d", want.eor, rsp_chan.end_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
